// ===== src/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== src/ptts_pkg.sv =====
// Types and constants of the periodic task tick scheduler.
package ptts_pkg;

    localparam int DEFAULT_TASK_SLOTS = 8;

    localparam int ID_W     = 8;
    localparam int PERIOD_W = 16;
    localparam int PRIO_W   = 8;
    localparam int KIND_W   = 2;

    // Operation codes of an input word.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    // One stored task.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] counter;
        logic [PRIO_W-1:0]   prio;
    } ptts_entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } ptts_cmd_t;

endpackage

// ===== src/ptts_if.sv =====
// Request and response channel interfaces of the scheduler.
interface ptts_req_if;
    import ptts_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] task_period;
    logic [PRIO_W-1:0]   task_priority;

    modport source (output valid, output op, output task_id, output task_period,
                    output task_priority, input ready);
    modport sink   (input valid, input op, input task_id, input task_period,
                    input task_priority, output ready);
endinterface

interface ptts_rsp_if;
    import ptts_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   fired_id;
    logic              accepted;
    logic              last;

    modport source (output valid, output kind, output fired_id, output accepted,
                    output last, input ready);
    modport sink   (input valid, input kind, input fired_id, input accepted,
                    input last, output ready);
endinterface

// ===== src/ptts_cell.sv =====
// One task slot of the sorted chain: holds an entry and trades it with its neighbours.
module ptts_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptts_pkg::ptts_cmd_t cmd,
    input  ptts_pkg::ptts_entry_t new_data,
    input  logic                prev_valid,
    input  ptts_pkg::ptts_entry_t prev_data,
    input  logic                prev_greater,
    input  logic                next_valid,
    input  ptts_pkg::ptts_entry_t next_data,
    output logic                valid,
    output ptts_pkg::ptts_entry_t data,
    output logic                greater
);
    import ptts_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ptts_entry_t data_reg;
    ptts_entry_t data_next;

    // An empty slot counts as holding a larger priority than any new task.
    assign greater = !valid_reg || (data_reg.prio > new_data.prio);

    // Insert shifts towards the tail; rotation walks the chain towards the head.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.insert && greater)
        begin
            if (prev_greater)
            begin
                valid_next = prev_valid;
                data_next  = prev_data;
            end
            else
            begin
                valid_next = 1'b1;
                data_next  = new_data;
            end
        end
        else if (cmd.rotate)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== src/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler: cell chain and tick sequencer.
//
// The req channel takes one word per operation. An add word (op = 0) places a
// task into a chain of TASK_SLOTS cells kept sorted by ascending priority, after
// any task of equal priority; it is answered in the next cycle by a single
// acknowledge word on rsp, with accepted low when every slot was taken.
// A tick word (op = 1) walks the chain: each cycle, unless a fired word is
// held up by rsp, the head cell is updated and moved to the tail, so after
// TASK_SLOTS steps the order is restored. Every task whose counter reaches its
// period is reported as a fired word in priority order, and a done word with
// last high closes the tick. Words are taken one at a time; req.ready is high
// only while no tick is in progress and the response register is free or being
// emptied.
// A stalled receiver freezes the walk at the next fired task, nothing is lost.
// Reset empties every slot and clears the response register.
`include "assert_macros.svh"

module periodic_task_tick_scheduler #(
    parameter int TASK_SLOTS = ptts_pkg::DEFAULT_TASK_SLOTS
) (
    input logic      clk,
    input logic      rst_n,
    ptts_req_if.sink   req,
    ptts_rsp_if.source rsp
);
    import ptts_pkg::*;

    localparam int STEP_W = $clog2(TASK_SLOTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic [ID_W-1:0]   fired_id_reg;
    logic [ID_W-1:0]   fired_id_next;
    logic              accepted_reg;
    logic              accepted_next;
    logic              last_reg;
    logic              last_next;

    logic [TASK_SLOTS-1:0] valid_vec;
    logic [TASK_SLOTS-1:0] greater_vec;
    ptts_entry_t           cell_data [TASK_SLOTS];

    ptts_cmd_t   cmd;
    ptts_entry_t new_data;
    ptts_entry_t head_rot;
    logic [PERIOD_W-1:0] head_sum;
    logic        head_fire;
    logic        out_free;
    logic        accept;
    logic        full;
    logic        walk_done;
    logic [TASK_SLOTS-1:0] valid_inc;

    // Task built from an add word, counter starting at zero.
    always_comb
    begin
        new_data.id      = req.task_id;
        new_data.period  = req.task_period;
        new_data.counter = '0;
        new_data.prio    = req.task_priority;
    end

    // Counter update of the head slot on its way to the tail.
    assign head_sum  = cell_data[0].counter + PERIOD_W'(1);
    assign head_fire = valid_vec[0] && (head_sum >= cell_data[0].period);

    always_comb
    begin
        head_rot         = cell_data[0];
        head_rot.counter = head_fire ? '0 : head_sum;
    end

    // The chain of task slots.
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        logic        prev_valid;
        ptts_entry_t prev_data;
        logic        prev_greater;
        logic        next_valid;
        ptts_entry_t next_data;

        if (i == 0)
        begin : g_head
            assign prev_valid   = 1'b0;
            assign prev_data    = '0;
            assign prev_greater = 1'b0;
        end
        else
        begin : g_body
            assign prev_valid   = valid_vec[i-1];
            assign prev_data    = cell_data[i-1];
            assign prev_greater = greater_vec[i-1];
        end

        if (i == TASK_SLOTS - 1)
        begin : g_tail
            assign next_valid = valid_vec[0];
            assign next_data  = head_rot;
        end
        else
        begin : g_link
            assign next_valid = valid_vec[i+1];
            assign next_data  = cell_data[i+1];
        end

        ptts_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .new_data     (new_data),
            .prev_valid   (prev_valid),
            .prev_data    (prev_data),
            .prev_greater (prev_greater),
            .next_valid   (next_valid),
            .next_data    (next_data),
            .valid        (valid_vec[i]),
            .data         (cell_data[i]),
            .greater      (greater_vec[i])
        );
    end

    // Handshake on the request side.
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = valid_vec[TASK_SLOTS-1];
    assign walk_done = (step_reg == STEP_W'(TASK_SLOTS));

    // Sequencer for adds and the tick walk.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd.insert     = 1'b0;
        cmd.rotate     = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        fired_id_next  = fired_id_reg;
        accepted_next  = accepted_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_ADD)
                    begin
                        cmd.insert     = !full;
                        rsp_valid_next = 1'b1;
                        kind_next      = KIND_ACK;
                        fired_id_next  = '0;
                        accepted_next  = !full;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TICK;
                        step_next  = '0;
                    end
                end
            end
            ST_TICK:
            begin
                if (!walk_done)
                begin
                    if (!head_fire || out_free)
                    begin
                        cmd.rotate = 1'b1;
                        step_next  = step_reg + STEP_W'(1);
                    end
                    if (head_fire && out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        kind_next      = KIND_FIRED;
                        fired_id_next  = cell_data[0].id;
                        accepted_next  = 1'b0;
                        last_next      = 1'b0;
                    end
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    kind_next      = KIND_DONE;
                    fired_id_next  = '0;
                    accepted_next  = 1'b0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        fired_id_reg <= fired_id_next;
        accepted_reg <= accepted_next;
        last_reg     <= last_next;
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.kind     = kind_reg;
    assign rsp.fired_id = fired_id_reg;
    assign rsp.accepted = accepted_reg;
    assign rsp.last     = last_reg;

    // Occupied slots form an unbroken run from the head when no tick is running.
    assign valid_inc = valid_vec + TASK_SLOTS'(1);

    `ASSERT_CLK(a_packed_slots, clk, rst_n,
        (state_reg == ST_IDLE) |-> ((valid_inc & valid_vec) == '0))
    `ASSERT_CLK(a_walk_keeps_tasks, clk, rst_n,
        (state_reg == ST_TICK) |=> ($countones(valid_vec) == $past($countones(valid_vec))))
    `ASSERT_NEVER(a_ready_in_tick, clk, rst_n,
        req.ready && (state_reg == ST_TICK))
    `ASSERT_NEVER(a_step_bound, clk, rst_n,
        step_reg > STEP_W'(TASK_SLOTS))

endmodule
